>>> rtl/core/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the polygon crossing-parity block: the
// transaction payloads, the controller states and the control links between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Field widths of the transactions and the configuration register.
  localparam int COORD_W          = 16;
  localparam int IDX_W            = 6;
  localparam int VCOUNT_W         = 7;
  localparam int CNT_W            = 7;
  localparam int MAX_VERTICES_DEF = 64;

  // Operation codes carried in the func field.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Input transaction: a vertex write or a point query.
  typedef struct packed {
    logic                       func;
    logic [IDX_W-1:0]           vertex_index;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
  } in_item_t;

  // Result transaction: crossing count and its parity.
  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] crossing_count;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;     // store the vertex of the accepted transaction
    logic start;     // capture the query point, clear count and read pointer
    logic rd_en;     // read the next vertex of the sweep
    logic load_out;  // copy the finished count into the result register
  } pip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_last;   // the read issued now is the closing one
    logic n_zero;    // no vertices in use
    logic busy;      // side tests still in flight
  } pip_sts_t;

endpackage

>>> rtl/core/pip_ctrl.sv
// ----------------------------------------------------------------------------
// pip_ctrl
// Controller for the polygon crossing-parity block. Accepts transactions,
// sequences the vertex sweep of a query and hands the result to the output.
// ----------------------------------------------------------------------------
module pip_ctrl
  import pip_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output pip_cmd_t cmd,
  input  pip_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_func == FUNC_QUERY) begin
            cmd.start = 1'b1;
            state_nxt = sts.n_zero ? ST_DRAIN : ST_SWEEP;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        cmd.rd_en = 1'b1;
        if (sts.rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Hand over once the pipeline is empty and the result register is free.
        if (!sts.busy && (!out_valid_r || out_ready)) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/pip_datapath.sv
// ----------------------------------------------------------------------------
// pip_datapath
// Vertex memory, sweep read pointer and the pipelined side test. Each vertex
// read forms one side with the vertex before it; the sign tests are exact.
// ----------------------------------------------------------------------------
module pip_datapath
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [VCOUNT_W-1:0] cfg_data,
  input  in_item_t            in_data,
  input  pip_cmd_t            cmd,
  output pip_sts_t            sts,
  output out_item_t           out_data
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int PW = 2 * COORD_W;
  localparam int KW = PW + 1;
  localparam int DW = PW + 3;

  logic [VCOUNT_W-1:0] vc_r;
  logic [NW-1:0]       n_eff;
  logic [NW-1:0]       rd_cnt_r;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                wr_ok;

  logic [2*COORD_W-1:0] mem [MAX_VERTICES];
  logic [2*COORD_W-1:0] rd_data_r;

  logic signed [COORD_W-1:0] qx_r, qy_r;
  logic signed [COORD_W-1:0] cx, cy;
  logic signed [COORD_W-1:0] pvx_r, pvy_r;
  logic                      s1_vld_r, s1_side_r;

  logic signed [PW-1:0] mk1_r, mk2_r, mc1_r, mc2_r;
  logic                 s2_vld_r, s2_side_r;

  logic signed [KW-1:0] k_r, kp_r, c_r;
  logic                 s3_vld_r, s3_side_r;

  logic signed [DW-1:0] d2;
  logic                 t1_miss, t2_miss, hit;
  logic [CNT_W-1:0]     count_r;
  out_item_t            out_r;

  // Vertex count register, clamped to the table size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= '0;
    end else if (cfg_we) begin
      vc_r <= cfg_data;
    end
  end

  assign n_eff = (int'(vc_r) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vc_r);

  // Read pointer: vertices 0 to n-1, then vertex 0 again for the closing side.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_cnt_r <= '0;
    end else if (cmd.rd_en) begin
      rd_cnt_r <= rd_cnt_r + 1'b1;
    end
  end

  assign rd_addr = (rd_cnt_r == n_eff) ? '0 : rd_cnt_r[AW-1:0];
  assign wr_addr = AW'(in_data.vertex_index);
  assign wr_ok   = int'(in_data.vertex_index) < MAX_VERTICES;

  // Vertex memory, x in the upper half and y in the lower half.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[wr_addr] <= {in_data.point_x, in_data.point_y};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Query point capture.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx_r <= in_data.point_x;
      qy_r <= in_data.point_y;
    end
  end

  // Stage 1 tags: the first read has no side before it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.rd_en;
    end
    s1_side_r <= (rd_cnt_r != '0);
  end

  assign cx = $signed(rd_data_r[2*COORD_W-1:COORD_W]);
  assign cy = $signed(rd_data_r[COORD_W-1:0]);

  // Previous vertex, the start of the side ending at the current vertex.
  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      pvx_r <= cx;
      pvy_r <= cy;
    end
  end

  // Stage 2: the four products of the side test.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_side_r <= s1_side_r;
    mk1_r     <= qy_r * cx;
    mk2_r     <= qx_r * cy;
    mc1_r     <= cx * pvy_r;
    mc2_r     <= pvx_r * cy;
  end

  // Stage 3: cross product of the query point with each end, and the
  // constant term of the side's line.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_side_r <= s2_side_r;
    if (s2_vld_r) begin
      k_r  <= KW'(mk1_r) - KW'(mk2_r);
      kp_r <= k_r;
      c_r  <= KW'(mc1_r) - KW'(mc2_r);
    end
  end

  // Stage 4: sign tests. The side is missed when both ends lie strictly on
  // one side of the query line, or the origin and the query point lie
  // strictly on one side of the side's line.
  assign d2 = DW'(kp_r) - DW'(k_r) + DW'(c_r);

  assign t1_miss = (!kp_r[KW-1] && (|kp_r) && !k_r[KW-1] && (|k_r)) ||
                   (kp_r[KW-1] && k_r[KW-1]);
  assign t2_miss = (!c_r[KW-1] && (|c_r) && !d2[DW-1] && (|d2)) ||
                   (c_r[KW-1] && d2[DW-1]);
  assign hit     = !t1_miss && !t2_miss;

  // Crossing counter, reported modulo its width.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      count_r <= '0;
    end else if (s3_vld_r && s3_side_r && hit) begin
      count_r <= count_r + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.inside_res     <= count_r[0];
      out_r.crossing_count <= count_r;
    end
  end

  assign out_data    = out_r;
  assign sts.rd_last = (rd_cnt_r == n_eff);
  assign sts.n_zero  = (n_eff == '0);
  assign sts.busy    = s1_vld_r || s2_vld_r || s3_vld_r;

endmodule

>>> rtl/core/point_in_polygon_parity.sv
// ----------------------------------------------------------------------------
// point_in_polygon_parity
// Polygon containment by crossing parity over a stored vertex table.
// ----------------------------------------------------------------------------
// Usage:
// The cfg channel writes the vertex count; it is always ready and should be
// written only while no query is in progress. Sides run from vertex i to
// vertex i+1 and close from the last vertex back to vertex 0.
// An in transaction with func = write stores one vertex in the table;
// it gives no result. A query transaction gives one out transaction holding
// the crossing count and its parity.
// A query with n vertices in use reads n + 1 vertices from the table, one
// per cycle, then drains a four-stage side-test pipeline before the result
// is offered. With no vertices in use the query reads no vertex and its
// result is offered without a sweep.
// The result sits in an output register; while the receiver stalls, further
// vertex writes are still taken, and a following query finishes its sweep
// and then waits for the register to empty.
// Reset clears the vertex count and the control state; table entries stay
// undefined until written.
// ----------------------------------------------------------------------------
module point_in_polygon_parity
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [VCOUNT_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  pip_cmd_t cmd;
  pip_sts_t sts;

  assign cfg_ready = 1'b1;

  // Transaction sequencing.
  pip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Vertex table and side-test pipeline.
  pip_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the polygon crossing-parity block. Vertex writes and
// point queries are fed through a valid/ready driver with random gaps, and the
// result channel is stalled at random. Each query's crossing count and parity
// are worked out from a local copy of the vertex table and vertex count, then
// compared field by field with the result transactions in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pip_pkg::*;

  localparam int TABLE_DEPTH    = MAX_VERTICES_DEF;
  localparam int MAX_WAIT       = 16;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 600;

  // Coordinate ranges used to shape polygons and query points.
  typedef enum int {
    SPAN_FULL,
    SPAN_TINY,
    SPAN_MID,
    SPAN_EDGE
  } coord_span_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [VCOUNT_W-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;

  // Pending input transactions and the crossing results still owed.
  in_item_t  stim_queue[$];
  out_item_t crossing_expect[$];

  // Local copy of the block's vertex table and vertex count.
  longint vert_x[TABLE_DEPTH];
  longint vert_y[TABLE_DEPTH];
  int     vertex_limit = 0;

  bit in_fire, out_fire, cfg_fire;
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;
  int in_wait  = 0;
  int out_wait = 0;

  int        mismatch_count  = 0;
  int        results_checked = 0;
  int        vertex_writes   = 0;
  int        cfg_writes      = 0;
  int        peak_crossings  = 0;
  int        quiet_cycles    = 0;
  int        issued          = 0;
  int        crossings;
  out_item_t expected_res;
  int        lead_counts[7]  = '{64, 127, 0, 1, 2, 3, 65};

  point_in_polygon_parity u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock: 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // True unless both points lie strictly on the same side of the line a-b.
  function automatic bit not_same_side(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py, longint qx, longint qy);
    longint la, lb, lc, d1, d2;
    la = by - ay;
    lb = ax - bx;
    lc = bx * ay - ax * by;
    d1 = la * px + lb * py + lc;
    d2 = la * qx + lb * qy + lc;
    return !((d1 > 0 && d2 > 0) || (d1 < 0 && d2 < 0));
  endfunction

  // Number of closed polygon sides that the origin-to-point segment touches.
  function automatic int count_crossings(longint px, longint py);
    int n, j, hits;
    hits = 0;
    n = (vertex_limit > TABLE_DEPTH) ? TABLE_DEPTH : vertex_limit;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 < n) ? i + 1 : 0;
      if (not_same_side(0, 0, px, py, vert_x[i], vert_y[i], vert_x[j], vert_y[j]) &&
          not_same_side(vert_x[i], vert_y[i], vert_x[j], vert_y[j], 0, 0, px, py))
        hits++;
    end
    return hits;
  endfunction

  function automatic int draw_coord(coord_span_t span);
    case (span)
      SPAN_FULL: return int'($urandom_range(0, 65535)) - 32768;
      SPAN_TINY: return int'($urandom_range(0, 16)) - 8;
      SPAN_MID:  return int'($urandom_range(0, 4000)) - 2000;
      default: begin
        case ($urandom_range(0, 4))
          0:       return -32768;
          1:       return -1;
          2:       return 0;
          3:       return 1;
          default: return 32767;
        endcase
      end
    endcase
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic push_item(input logic func, input int idx, input int x, input int y);
    in_item_t item;
    item.func         = func;
    item.vertex_index = idx[IDX_W-1:0];
    item.point_x      = x[COORD_W-1:0];
    item.point_y      = y[COORD_W-1:0];
    stim_queue = {stim_queue, item};
    issued++;
  endtask

  // Wait until every transaction is taken and every result has arrived, then
  // give a trailing vertex write time to settle.
  task automatic wait_idle();
    while (stim_queue.size() != 0 || in_valid || crossing_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[VCOUNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Input driver: one transaction at a time, with a random gap after each.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait--;
      end else if (stim_queue.size() > 0) begin
        in_data  <= stim_queue.pop_front();
        in_valid <= 1'b1;
        in_wait  = draw_wait(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: after each result taken, hold ready low for a random stall.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire)
        out_wait = draw_wait(out_calm);
      if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: tracks the block's state on each accepted transaction, checks the
  // results and watches for a stalled run.
  always @(posedge clk) begin
    in_fire  = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    cfg_fire = rst_n && cfg_valid && cfg_ready;
    if (cfg_fire) begin
      vertex_limit = int'(cfg_data);
      cfg_writes++;
    end
    if (in_fire) begin
      if (in_data.func == FUNC_WRITE) begin
        vert_x[in_data.vertex_index] = longint'($signed(in_data.point_x));
        vert_y[in_data.vertex_index] = longint'($signed(in_data.point_y));
        vertex_writes++;
      end else begin
        crossings = count_crossings(longint'($signed(in_data.point_x)),
                                    longint'($signed(in_data.point_y)));
        expected_res.inside_res     = crossings[0];
        expected_res.crossing_count = crossings[CNT_W-1:0];
        crossing_expect = {crossing_expect, expected_res};
        if (crossings > peak_crossings)
          peak_crossings = crossings;
      end
    end
    if (out_fire) begin
      if (crossing_expect.size() == 0) begin
        report_mismatch($sformatf("result with none expected: inside %0b count %0d",
                                  out_data.inside_res, out_data.crossing_count));
      end else begin
        expected_res = crossing_expect.pop_front();
        if (out_data.inside_res !== expected_res.inside_res)
          report_mismatch($sformatf("inside_res got %0b expected %0b",
                                    out_data.inside_res, expected_res.inside_res));
        if (out_data.crossing_count !== expected_res.crossing_count)
          report_mismatch($sformatf("crossing_count got %0d expected %0d",
                                    out_data.crossing_count, expected_res.crossing_count));
        results_checked++;
      end
    end
    if (!rst_n || in_fire || out_fire || cfg_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int          count_setting;
    int          limit;
    int          burst;
    int          phase_no;
    coord_span_t span;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // With no vertices in use every query reports zero.
    push_item(FUNC_QUERY, 0, 0, 0);
    push_item(FUNC_QUERY, 0, 32767, -32768);

    // A square around the origin, plus the last table entry at the extremes.
    push_item(FUNC_WRITE, 63, -32768, 32767);
    push_item(FUNC_WRITE, 0, -1000, -1000);
    push_item(FUNC_WRITE, 1, 1000, -1000);
    push_item(FUNC_WRITE, 2, 1000, 1000);
    push_item(FUNC_WRITE, 3, -1000, 1000);
    wait_idle();
    write_vertex_count(4);
    push_item(FUNC_QUERY, 0, 5000, 0);
    push_item(FUNC_QUERY, 0, 1000, 0);
    push_item(FUNC_QUERY, 0, 1000, 1000);
    push_item(FUNC_QUERY, 0, 0, 0);
    push_item(FUNC_QUERY, 0, -32768, -32768);
    push_item(FUNC_QUERY, 0, 32767, -1);
    push_item(FUNC_QUERY, 0, 0, -3000);

    // A single vertex: the closing side degenerates to a point.
    wait_idle();
    write_vertex_count(1);
    push_item(FUNC_QUERY, 0, -1000, -1000);
    push_item(FUNC_QUERY, 0, 5, 5);

    // A triangle with one side on the x axis, so queries along it are collinear.
    push_item(FUNC_WRITE, 0, -500, 0);
    push_item(FUNC_WRITE, 1, 500, 0);
    push_item(FUNC_WRITE, 2, 0, 800);
    wait_idle();
    write_vertex_count(3);
    push_item(FUNC_QUERY, 0, -2000, 0);
    push_item(FUNC_QUERY, 0, 300, 0);
    push_item(FUNC_QUERY, 0, 0, 0);

    // Random part: fill the whole table first so that no unwritten entry is read.
    issued = 0;
    for (int i = 0; i < TABLE_DEPTH; i++)
      push_item(FUNC_WRITE, i, draw_coord(SPAN_FULL), draw_coord(SPAN_FULL));

    phase_no = 0;
    while (issued < RANDOM_ITEMS) begin
      if (phase_no < $size(lead_counts))
        count_setting = lead_counts[phase_no];
      else if ($urandom_range(0, 3) != 0)
        count_setting = $urandom_range(0, 12);
      else
        count_setting = $urandom_range(0, 127);
      wait_idle();
      write_vertex_count(count_setting);

      span     = coord_span_t'($urandom_range(0, 3));
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);

      // In about half of the phases, lay down a fresh polygon in the span that the queries use.
      limit = (count_setting > TABLE_DEPTH) ? TABLE_DEPTH : count_setting;
      if (limit > 0 && $urandom_range(0, 1) == 1)
        for (int i = 0; i < limit; i++)
          push_item(FUNC_WRITE, i, draw_coord(span), draw_coord(span));

      // Mostly queries near the polygon, with stray vertex rewrites mixed in.
      burst = $urandom_range(20, 40);
      repeat (burst) begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 4) == 0)
            push_item(FUNC_QUERY, $urandom_range(0, 63),
                      draw_coord(coord_span_t'($urandom_range(0, 3))),
                      draw_coord(coord_span_t'($urandom_range(0, 3))));
          else
            push_item(FUNC_QUERY, $urandom_range(0, 63), draw_coord(span), draw_coord(span));
        end else begin
          push_item(FUNC_WRITE, $urandom_range(0, 63), draw_coord(span), draw_coord(span));
        end
      end
      phase_no++;
    end

    wait_idle();
    $display("Checked %0d query results after %0d vertex writes and %0d vertex-count writes.",
             results_checked, vertex_writes, cfg_writes);
    $display("Vertex counts ranged from 0 to 127; the largest crossing count seen was %0d.",
             peak_crossings);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/pip_pkg.sv
rtl/core/pip_ctrl.sv
rtl/core/pip_datapath.sv
rtl/core/point_in_polygon_parity.sv
tb/sv/testbench.sv
